// ----- sv/frame_bitmap_allocator_macros.svh -----
// Assertion macros for the checker file.
`ifndef FRAME_BITMAP_ALLOCATOR_MACROS_SVH
`define FRAME_BITMAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame allocator check failed");

// Next-cycle implication, disabled during reset.
`define FBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame allocator check failed");

`endif

// ----- sv/fba_pkg.sv -----
// Package: field widths, command and status codes, reset constants.
package fba_pkg;

  localparam int CMD_W   = 3;
  localparam int FRAME_W = 16;
  localparam int LEN_W   = 17;
  localparam int CNT_W   = 17;
  localparam int ST_W    = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESERVE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RECOUNT = 3'd4;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [ST_W-1:0] ST_DBLFREE = 2'd2;
  localparam logic [ST_W-1:0] ST_INVALID = 2'd3;

  localparam int PAGE_BYTES = 4096;
  localparam int MIB        = 1048576;
  localparam int HINT_RESET = MIB / PAGE_BYTES;

  localparam logic [CNT_W-1:0] COUNT_MAX  = 17'h1FFFF;
  localparam logic [CNT_W-1:0] USED_RESET = 17'h10000;
  localparam logic [CNT_W-1:0] FC_RESET   = 17'h10000;

endpackage

// ----- sv/fba_if.sv -----
// Channel interfaces: request, result and configuration.
interface fba_in_if;
  logic                          valid;
  logic                          ready;
  logic [fba_pkg::CMD_W-1:0]     command;
  logic [fba_pkg::FRAME_W-1:0]   first_frame;
  logic [fba_pkg::LEN_W-1:0]     run_length;
  logic                          out_of_range;
  modport source (output valid, command, first_frame, run_length, out_of_range,
                  input ready);
  modport sink   (input valid, command, first_frame, run_length, out_of_range,
                  output ready);
endinterface

interface fba_out_if;
  logic                          valid;
  logic                          ready;
  logic [fba_pkg::FRAME_W-1:0]   frame_number;
  logic [fba_pkg::ST_W-1:0]      status;
  logic [fba_pkg::CNT_W-1:0]     used_total;
  logic [fba_pkg::CNT_W-1:0]     free_total;
  modport source (output valid, frame_number, status, used_total, free_total,
                  input ready);
  modport sink   (input valid, frame_number, status, used_total, free_total,
                  output ready);
endinterface

interface fba_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [fba_pkg::CNT_W-1:0]     frame_count;
  modport source (output valid, frame_count, input ready);
  modport sink   (input valid, frame_count, output ready);
endinterface

// ----- sv/fba_map_ram.sv -----
// Usage map storage: one write port, one registered read port.
module fba_map_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/frame_bitmap_allocator.sv -----
// Page frame allocator: bitmap in one memory, word-wise read-modify-write.
//
// One used bit per frame lives in a single-port-read, single-port-write memory
// of map words (MAP_WORD_BITS rounded up to a power of two frames per word).
// After reset a clearing pass writes every word to all-used, and no item is
// accepted meanwhile; frame_count writes are taken at any time.
// One item is worked at a time. Each map word visited is read, then modified
// and written back, so the memory port sets the pace: free reads and writes
// back the word of its frame; a single-frame allocate scans words from the
// hint (up to the whole map once, split over the pass from the hint and the
// pass from frame 0, when full); reserve, release and recount visit each word
// of the range; a run allocate reads words from frame 0, skips fully used
// words, steps one frame per cycle within a word once a free frame is seen,
// then writes the run word by word.
// Results sit in an output register, so a new item is accepted while the
// previous result waits to be taken.
module frame_bitmap_allocator #(
  parameter int FRAME_LIMIT   = 65536,
  parameter int MAP_WORD_BITS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  fba_in_if.sink    in_if,
  fba_out_if.source out_if,
  fba_cfg_if.sink   cfg_if
);

  localparam int BSH   = $clog2(MAP_WORD_BITS);
  localparam int WB    = 1 << BSH;
  localparam int WORDS = (FRAME_LIMIT + WB - 1) / WB;
  localparam int AW    = WORDS > 1 ? $clog2(WORDS) : 1;
  localparam int FW    = $clog2(FRAME_LIMIT + 1);
  localparam int XW    = (FW > 17 ? FW : 17) + 1;
  localparam int PW    = BSH + 1;
  localparam logic [XW-1:0] FL_X = XW'(FRAME_LIMIT);
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_START, S_RD, S_OP, S_BIT, S_DONE
  } state_t;

  typedef enum logic [2:0] {
    OP_SINGLE, OP_RUN, OP_SET, OP_CLR, OP_FREE, OP_COUNT
  } op_t;

  state_t  state_r;
  op_t     op_r;
  logic    pass_r;      // single allocate: second pass from frame 0
  logic    runw_r;      // run allocate: writing the found run
  logic [AW-1:0] w_r;
  logic [XW-1:0] lo_r, hi_r, f_r, run_r, start_r, len_r, acc_r, first_r;
  logic [XW-1:0] hint_r;
  logic [fba_pkg::CNT_W-1:0] used_r, fc_r;
  logic [WB-1:0] data_r;
  logic [fba_pkg::FRAME_W-1:0] res_frame_r;
  logic [fba_pkg::ST_W-1:0]    res_status_r;
  logic          out_valid_r;
  logic [fba_pkg::FRAME_W-1:0] out_frame_r;
  logic [fba_pkg::ST_W-1:0]    out_status_r;
  logic [fba_pkg::CNT_W-1:0]   out_used_r, out_free_r;

  // memory ports
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  logic [WB-1:0] mem_wdata, rdata;

  // word helpers
  logic [XW-1:0] base, lim, next_base, f_nxt, run_nxt, start_nxt;
  logic [WB-1:0] mask, free_bits, used_bits;
  logic          ff_any, last_word, cur_bit;
  logic [BSH-1:0] ff_idx;
  logic [PW-1:0] pop_free, pop_used;
  logic [XW-1:0] in_first, in_len, in_end;

  function automatic logic [fba_pkg::CNT_W-1:0] sat_add(
    input logic [fba_pkg::CNT_W-1:0] a, input logic [PW-1:0] n);
    logic [fba_pkg::CNT_W:0] s;
    s = {1'b0, a} + (fba_pkg::CNT_W+1)'(n);
    return s[fba_pkg::CNT_W] ? fba_pkg::COUNT_MAX : s[fba_pkg::CNT_W-1:0];
  endfunction

  function automatic logic [fba_pkg::CNT_W-1:0] sat_sub(
    input logic [fba_pkg::CNT_W-1:0] a, input logic [PW-1:0] n);
    logic [fba_pkg::CNT_W-1:0] nx;
    nx = fba_pkg::CNT_W'(n);
    return (a >= nx) ? a - nx : '0;
  endfunction

  always_comb begin
    lim       = (XW'(fc_r) < FL_X) ? XW'(fc_r) : FL_X;
    base      = XW'(w_r) << BSH;
    next_base = base + XW'(WB);
    for (int i = 0; i < WB; i++) begin
      mask[i] = ((base + XW'(i)) >= lo_r) && ((base + XW'(i)) < hi_r);
    end
    free_bits = ~rdata & mask;
    used_bits = rdata & mask;
    ff_any    = |free_bits;
    ff_idx    = '0;
    for (int i = WB - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        ff_idx = BSH'(i);
      end
    end
    pop_free  = PW'($countones(free_bits));
    pop_used  = PW'($countones(used_bits));
    last_word = (w_r == AW'((hi_r - XW'(1)) >> BSH));
    // run search, one frame per step
    cur_bit   = data_r[f_r[BSH-1:0]];
    run_nxt   = cur_bit ? '0 : run_r + XW'(1);
    start_nxt = (!cur_bit && run_r == '0) ? f_r : start_r;
    f_nxt     = f_r + XW'(1);
    in_first  = XW'(in_if.first_frame);
    in_len    = XW'(in_if.run_length);
    in_end    = ((in_first + in_len) > FL_X) ? FL_X : in_first + in_len;
  end

  // write-back data and clearing pass
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = w_r;
    mem_wdata = rdata;
    mem_re    = (state_r == S_RD);
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_wdata = '1;
    end else if (state_r == S_OP) begin
      case (op_r)
        OP_SINGLE: begin
          mem_we    = ff_any;
          mem_wdata = rdata | (WB'(1) << ff_idx);
        end
        OP_FREE: begin
          mem_we    = rdata[first_r[BSH-1:0]];
          mem_wdata = rdata & ~(WB'(1) << first_r[BSH-1:0]);
        end
        OP_SET: begin
          mem_we    = 1'b1;
          mem_wdata = rdata | mask;
        end
        OP_CLR: begin
          mem_we    = 1'b1;
          mem_wdata = rdata & ~mask;
        end
        default: begin
          mem_we = 1'b0;
        end
      endcase
    end
  end

  fba_map_ram #(.DEPTH(WORDS), .WIDTH(WB)) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (w_r),
    .rdata (rdata)
  );

  assign in_if.ready   = (state_r == S_IDLE);
  assign cfg_if.ready  = 1'b1;
  assign out_if.valid        = out_valid_r;
  assign out_if.frame_number = out_frame_r;
  assign out_if.status       = out_status_r;
  assign out_if.used_total   = out_used_r;
  assign out_if.free_total   = out_free_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      op_r        <= OP_SINGLE;
      w_r         <= '0;
      pass_r      <= 1'b0;
      runw_r      <= 1'b0;
      used_r      <= fba_pkg::USED_RESET;
      fc_r        <= fba_pkg::FC_RESET;
      hint_r      <= XW'(fba_pkg::HINT_RESET);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        fc_r <= cfg_if.frame_count;
      end
      // taken result; S_DONE reloads the register itself
      if (out_valid_r && out_if.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          w_r <= w_r + AW'(1);
          if (w_r == LAST_WORD) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_if.valid) begin
            first_r      <= in_first;
            len_r        <= in_len;
            runw_r       <= 1'b0;
            pass_r       <= 1'b0;
            res_frame_r  <= '0;
            res_status_r <= fba_pkg::ST_OK;
            acc_r        <= '0;
            state_r      <= S_START;
            case (in_if.command)
              fba_pkg::CMD_ALLOC: begin
                if (in_len == '0) begin
                  res_status_r <= fba_pkg::ST_NOSPACE;
                  state_r      <= S_DONE;
                end else if (in_len == XW'(1)) begin
                  op_r <= OP_SINGLE;
                  lo_r <= hint_r;
                  hi_r <= lim;
                end else begin
                  op_r  <= OP_RUN;
                  lo_r  <= '0;
                  f_r   <= '0;
                  run_r <= '0;
                  hi_r  <= lim;
                end
              end
              fba_pkg::CMD_FREE: begin
                if (in_if.out_of_range || in_first >= FL_X) begin
                  res_status_r <= fba_pkg::ST_INVALID;
                  state_r      <= S_DONE;
                end else begin
                  op_r <= OP_FREE;
                  lo_r <= in_first;
                  hi_r <= in_first + XW'(1);
                end
              end
              fba_pkg::CMD_RESERVE, fba_pkg::CMD_RELEASE: begin
                op_r <= (in_if.command == fba_pkg::CMD_RESERVE) ? OP_SET : OP_CLR;
                lo_r <= in_first;
                hi_r <= in_end;
              end
              fba_pkg::CMD_RECOUNT: begin
                op_r <= OP_COUNT;
                lo_r <= '0;
                hi_r <= lim;
              end
              default: begin
                state_r <= S_DONE;   // unused codes: no effect
              end
            endcase
          end
        end
        S_START: begin
          if (lo_r < hi_r) begin
            w_r     <= AW'(lo_r >> BSH);
            state_r <= S_RD;
          end else begin
            state_r <= S_DONE;
            case (op_r)
              OP_SINGLE: begin
                if (!pass_r) begin
                  pass_r  <= 1'b1;
                  lo_r    <= '0;
                  hi_r    <= (hint_r < lim) ? hint_r : lim;
                  state_r <= S_START;
                end else begin
                  res_status_r <= fba_pkg::ST_NOSPACE;
                end
              end
              OP_RUN:   res_status_r <= fba_pkg::ST_NOSPACE;
              OP_COUNT: used_r <= '0;
              default:  res_status_r <= fba_pkg::ST_OK;
            endcase
          end
        end
        S_RD: begin
          state_r <= S_OP;
        end
        S_OP: begin
          case (op_r)
            OP_SINGLE: begin
              if (ff_any) begin
                used_r      <= sat_add(used_r, PW'(1));
                hint_r      <= base + XW'(ff_idx) + XW'(1);
                res_frame_r <= fba_pkg::FRAME_W'(base + XW'(ff_idx));
                state_r     <= S_DONE;
              end else if (last_word) begin
                if (!pass_r) begin
                  pass_r  <= 1'b1;
                  lo_r    <= '0;
                  hi_r    <= (hint_r < lim) ? hint_r : lim;
                  state_r <= S_START;
                end else begin
                  res_status_r <= fba_pkg::ST_NOSPACE;
                  state_r      <= S_DONE;
                end
              end else begin
                w_r     <= w_r + AW'(1);
                state_r <= S_RD;
              end
            end
            OP_FREE: begin
              if (!rdata[first_r[BSH-1:0]]) begin
                res_status_r <= fba_pkg::ST_DBLFREE;
              end else begin
                used_r <= sat_sub(used_r, PW'(1));
                if (first_r < hint_r) begin
                  hint_r <= first_r;
                end
              end
              state_r <= S_DONE;
            end
            OP_SET, OP_CLR, OP_COUNT: begin
              if (op_r == OP_SET) begin
                used_r <= sat_add(used_r, pop_free);
              end else if (op_r == OP_CLR) begin
                used_r <= sat_sub(used_r, pop_used);
              end else begin
                acc_r <= acc_r + XW'(pop_used);
                if (last_word) begin
                  used_r <= ((acc_r + XW'(pop_used)) > XW'(fba_pkg::COUNT_MAX)) ?
                            fba_pkg::COUNT_MAX :
                            fba_pkg::CNT_W'(acc_r + XW'(pop_used));
                end
              end
              if (last_word) begin
                if (runw_r) begin
                  res_frame_r <= fba_pkg::FRAME_W'(start_r);
                end
                state_r <= S_DONE;
              end else begin
                w_r     <= w_r + AW'(1);
                state_r <= S_RD;
              end
            end
            OP_RUN: begin
              data_r <= rdata;
              if (run_r != '0) begin
                state_r <= S_BIT;
              end else if (ff_any) begin
                f_r     <= base + XW'(ff_idx);
                state_r <= S_BIT;
              end else if (next_base >= hi_r) begin
                res_status_r <= fba_pkg::ST_NOSPACE;
                state_r      <= S_DONE;
              end else begin
                // whole word used: skip it
                f_r     <= next_base;
                lo_r    <= next_base;
                w_r     <= w_r + AW'(1);
                state_r <= S_RD;
              end
            end
            default: begin
              state_r <= S_DONE;
            end
          endcase
        end
        S_BIT: begin
          if (f_r >= hi_r) begin
            res_status_r <= fba_pkg::ST_NOSPACE;
            state_r      <= S_DONE;
          end else begin
            run_r   <= run_nxt;
            start_r <= start_nxt;
            f_r     <= f_nxt;
            if (run_nxt == len_r) begin
              // run found: set its bits as a reserve pass
              op_r    <= OP_SET;
              runw_r  <= 1'b1;
              lo_r    <= start_nxt;
              hi_r    <= start_nxt + len_r;
              state_r <= S_START;
            end else if (f_r[BSH-1:0] == '1) begin
              lo_r    <= f_nxt;
              state_r <= S_START;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_if.ready) begin
            out_valid_r  <= 1'b1;
            out_frame_r  <= (res_status_r == fba_pkg::ST_OK) ? res_frame_r : '0;
            out_status_r <= res_status_r;
            out_used_r   <= used_r;
            out_free_r   <= (fc_r > used_r) ? fc_r - used_r : '0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/fba_checker.sv -----
// Port-level checker for the frame allocator, bound to the top level.
`include "frame_bitmap_allocator_macros.svh"

module fba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_frame_number,
  input logic [1:0]  out_status
);

  logic st_fail;

  assign st_fail = (out_status != fba_pkg::ST_OK);

  `FBA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
  `FBA_ASSERT_NOW(a_fail_no_frame, clk, rst_n, out_valid && st_fail, out_frame_number == '0)
  `FBA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `FBA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready && !out_valid, !out_valid)

endmodule

bind frame_bitmap_allocator fba_checker u_fba_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_frame_number (out_if.frame_number),
  .out_status       (out_if.status)
);

// ----- tb/frame_bitmap_allocator_tb.sv -----
// Testbench for frame_bitmap_allocator: random and directed requests checked against a map model.
`timescale 1ns / 1ps

module frame_bitmap_allocator_tb;

  localparam int          MAP_FRAMES  = 65536;
  localparam int          CYCLE_LIMIT = 20000000;
  localparam int unsigned RESET_HINT  = fba_pkg::HINT_RESET;

  typedef struct packed {
    logic [fba_pkg::CMD_W-1:0]   command;
    logic [fba_pkg::FRAME_W-1:0] first_frame;
    logic [fba_pkg::LEN_W-1:0]   run_length;
    logic                        out_of_range;
  } request_t;

  typedef struct packed {
    logic [fba_pkg::FRAME_W-1:0] frame_number;
    logic [fba_pkg::ST_W-1:0]    status;
    logic [fba_pkg::CNT_W-1:0]   used_total;
    logic [fba_pkg::CNT_W-1:0]   free_total;
  } outcome_t;

  // Model of the allocator: usage bitmap, counter, hint and frame_count, plus the
  // outcomes still owed by the block, oldest first.
  class frame_map_model;
    bit          frame_used [MAP_FRAMES];
    int unsigned used_count;
    int unsigned hint;
    int unsigned frame_total;
    outcome_t    owed [$];
    int          mismatches;

    function new();
      foreach (frame_used[i]) frame_used[i] = 1'b1;
      used_count  = 32'(fba_pkg::USED_RESET);
      hint        = RESET_HINT;
      frame_total = 32'(fba_pkg::FC_RESET);
      mismatches  = 0;
    endfunction

    function void set_frame_total(int unsigned v);
      frame_total = v;
    endfunction

    function int unsigned first_clear(int unsigned lo, int unsigned hi);
      for (int unsigned f = lo; f < hi; f++)
        if (!frame_used[f]) return f;
      return hi;
    endfunction

    function void bump(bit up);
      if (up) begin
        if (used_count < 32'(fba_pkg::COUNT_MAX)) used_count++;
      end else if (used_count > 0) begin
        used_count--;
      end
    endfunction

    // Work out the outcome of one accepted item and queue it.
    function void note_request(request_t r);
      int unsigned lim, hi2, f, run, start, stop, n, len, first;
      bit          found;
      outcome_t    o;
      lim   = (frame_total < MAP_FRAMES) ? frame_total : MAP_FRAMES;
      len   = 32'(r.run_length);
      first = 32'(r.first_frame);
      o     = '0;
      o.status = fba_pkg::ST_OK;
      case (r.command)
        fba_pkg::CMD_ALLOC: begin
          if (len == 0) begin
            o.status = fba_pkg::ST_NOSPACE;
          end else if (len == 1) begin
            // next fit: hint up to the limit, then wrap to zero
            hi2   = (hint < lim) ? hint : lim;
            f     = first_clear(hint, lim);
            found = (f < lim);
            if (!found) begin
              f     = first_clear(0, hi2);
              found = (f < hi2);
            end
            if (!found) begin
              o.status = fba_pkg::ST_NOSPACE;
            end else begin
              frame_used[f] = 1'b1;
              bump(1'b1);
              hint = f + 1;
              o.frame_number = fba_pkg::FRAME_W'(f);
            end
          end else begin
            // first fit from frame zero, hint untouched
            run   = 0;
            start = 0;
            found = 1'b0;
            for (f = 0; f < lim && !found; f++) begin
              if (frame_used[f]) begin
                run = 0;
              end else begin
                if (run == 0) start = f;
                run++;
                if (run == len) found = 1'b1;
              end
            end
            if (!found) begin
              o.status = fba_pkg::ST_NOSPACE;
            end else begin
              for (f = start; f < start + len; f++) begin
                frame_used[f] = 1'b1;
                bump(1'b1);
              end
              o.frame_number = fba_pkg::FRAME_W'(start);
            end
          end
        end
        fba_pkg::CMD_FREE: begin
          if (r.out_of_range || first >= MAP_FRAMES) begin
            o.status = fba_pkg::ST_INVALID;
          end else if (!frame_used[first]) begin
            o.status = fba_pkg::ST_DBLFREE;
          end else begin
            frame_used[first] = 1'b0;
            bump(1'b0);
            if (first < hint) hint = first;
          end
        end
        fba_pkg::CMD_RESERVE, fba_pkg::CMD_RELEASE: begin
          stop = first + len;
          if (stop > MAP_FRAMES) stop = MAP_FRAMES;
          for (f = first; f < stop; f++) begin
            if (r.command == fba_pkg::CMD_RESERVE && !frame_used[f]) begin
              frame_used[f] = 1'b1;
              bump(1'b1);
            end else if (r.command == fba_pkg::CMD_RELEASE && frame_used[f]) begin
              frame_used[f] = 1'b0;
              bump(1'b0);
            end
          end
        end
        fba_pkg::CMD_RECOUNT: begin
          n = 0;
          for (f = 0; f < lim; f++) n += 32'(frame_used[f]);
          used_count = (n > 32'(fba_pkg::COUNT_MAX)) ? 32'(fba_pkg::COUNT_MAX) : n;
        end
        default: ;
      endcase
      if (o.status != fba_pkg::ST_OK) o.frame_number = '0;
      o.used_total = fba_pkg::CNT_W'(used_count);
      o.free_total = fba_pkg::CNT_W'((frame_total > used_count) ?
                                     frame_total - used_count : 0);
      owed.push_back(o);
    endfunction

    function void check_result(outcome_t a);
      outcome_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $realtime, a);
        mismatches++;
        return;
      end
      e = owed.pop_front();
      if (a.frame_number !== e.frame_number) begin
        $display("%0t: frame_number expected %0d actual %0d",
                 $realtime, e.frame_number, a.frame_number);
        mismatches++;
      end
      if (a.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, e.status, a.status);
        mismatches++;
      end
      if (a.used_total !== e.used_total) begin
        $display("%0t: used_total expected %0d actual %0d",
                 $realtime, e.used_total, a.used_total);
        mismatches++;
      end
      if (a.free_total !== e.free_total) begin
        $display("%0t: free_total expected %0d actual %0d",
                 $realtime, e.free_total, a.free_total);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count = 0;
  int   stall_tick  = 0;

  fba_in_if  in_if ();
  fba_out_if out_if ();
  fba_cfg_if cfg_if ();

  frame_bitmap_allocator u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  frame_map_model model = new();

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a stuck handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[frame_bitmap_allocator] ERROR");
      $finish;
    end
  end

  // Receiver: cycles through always-ready, coin-flip, periodic and mostly-stalled
  // stretches so stalls land on every phase of the block's work.
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    case (stall_tick[8:7])
      2'd0: out_if.ready <= 1'b1;
      2'd1: out_if.ready <= 1'($urandom_range(0, 1));
      2'd2: out_if.ready <= (stall_tick % 5) != 0;
      default: out_if.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Values read here are those before the edge, so no race with the block.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      model.check_result({out_if.frame_number, out_if.status,
                          out_if.used_total, out_if.free_total});
  end

  // Present one item and hold it until taken; valid stays high for the caller.
  task automatic send_request(request_t r);
    in_if.command      <= r.command;
    in_if.first_frame  <= r.first_frame;
    in_if.run_length   <= r.run_length;
    in_if.out_of_range <= r.out_of_range;
    in_if.valid        <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    model.note_request(r);
  endtask

  // Drops valid and idles; a zero gap keeps valid up for back-to-back items.
  task automatic idle_sender(int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    idle_sender(1);
    while (model.owed.size() != 0) @(posedge clk);
  endtask

  // frame_count is only changed with nothing in flight.
  task automatic write_frame_total(int unsigned v);
    drain_results();
    cfg_if.frame_count <= fba_pkg::CNT_W'(v);
    cfg_if.valid       <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    model.set_frame_total(v);
  endtask

  function automatic request_t make_request(logic [fba_pkg::CMD_W-1:0] command,
                                            int unsigned first, int unsigned len,
                                            bit bad);
    request_t r;
    r.command      = command;
    r.first_frame  = fba_pkg::FRAME_W'(first);
    r.run_length   = fba_pkg::LEN_W'(len);
    r.out_of_range = bad;
    return r;
  endfunction

  // Random item; most frame numbers fall in a window near zero so that
  // allocations, frees and ranges keep meeting each other.
  function automatic request_t random_request(int unsigned span);
    int unsigned pick, first, len;
    bit          bad;
    pick  = $urandom_range(0, 99);
    first = $urandom_range(0, span - 1);
    bad   = 1'($urandom_range(0, 1));
    if (pick < 30) return make_request(fba_pkg::CMD_ALLOC, first, 1, bad);
    if (pick < 38) begin
      len = $urandom_range(2, 8);
      if ($urandom_range(0, 19) == 0) len = $urandom_range(0, 65536);
      return make_request(fba_pkg::CMD_ALLOC, first, len, bad);
    end
    if (pick < 63) begin
      if ($urandom_range(0, 19) == 0) first = $urandom_range(0, 65535);
      return make_request(fba_pkg::CMD_FREE, first, $urandom_range(0, 131071) % 65537,
                          $urandom_range(0, 19) == 0);
    end
    len = $urandom_range(0, 64);
    if ($urandom_range(0, 29) == 0) begin
      first = $urandom_range(0, 65535);
      len   = $urandom_range(0, 65536);
    end
    if (pick < 73) return make_request(fba_pkg::CMD_RESERVE, first, len, bad);
    if (pick < 93) return make_request(fba_pkg::CMD_RELEASE, first, len, bad);
    return make_request(fba_pkg::CMD_RECOUNT, first, len, bad);
  endfunction

  // One random phase: bursts of items with gaps, one full drain in the middle.
  task automatic random_phase(int unsigned span, int items);
    int burst;
    burst = 0;
    for (int i = 0; i < items; i++) begin
      if (i == items / 2) drain_results();
      send_request(random_request(span));
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        idle_sender($urandom_range(0, 1) ? $urandom_range(1, 6) : 0);
      end else begin
        burst--;
      end
    end
  endtask

  int unsigned frame_totals [8] = '{1000, 0, 131071, 300, 65535, 1, 2000, 65536};
  int unsigned lim, span;

  initial begin
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.command      <= fba_pkg::CMD_ALLOC;
    in_if.first_frame  <= '0;
    in_if.run_length   <= '0;
    in_if.out_of_range <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.frame_count <= fba_pkg::FC_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: every command, the field extremes and the corner cases.
    send_request(make_request(fba_pkg::CMD_ALLOC, 0, 0, 0));          // zero length
    send_request(make_request(fba_pkg::CMD_ALLOC, 0, 1, 0));          // map full
    send_request(make_request(fba_pkg::CMD_RELEASE, 0, 64, 0));
    send_request(make_request(fba_pkg::CMD_ALLOC, 0, 1, 0));          // hint wraps to zero
    send_request(make_request(fba_pkg::CMD_ALLOC, 0, 1, 1));
    send_request(make_request(fba_pkg::CMD_ALLOC, 0, 4, 0));          // first-fit run
    send_request(make_request(fba_pkg::CMD_ALLOC, 0, 65536, 0));      // run too long
    send_request(make_request(fba_pkg::CMD_FREE, 5, 0, 0));
    send_request(make_request(fba_pkg::CMD_FREE, 5, 0, 0));           // double free
    send_request(make_request(fba_pkg::CMD_FREE, 6, 0, 1));           // flagged invalid
    send_request(make_request(fba_pkg::CMD_FREE, 65535, 65536, 0));   // top frame
    send_request(make_request(fba_pkg::CMD_FREE, 65535, 0, 0));
    send_request(make_request(fba_pkg::CMD_RESERVE, 65535, 65536, 0)); // clipped range
    send_request(make_request(fba_pkg::CMD_RELEASE, 100, 0, 0));
    send_request(make_request(fba_pkg::CMD_RESERVE, 100, 0, 1));
    send_request(make_request(fba_pkg::CMD_RELEASE, 65000, 65536, 0));
    send_request(make_request(fba_pkg::CMD_RECOUNT, 0, 0, 0));
    send_request(make_request(fba_pkg::CMD_RESERVE, 0, 65536, 0));
    send_request(make_request(fba_pkg::CMD_RELEASE, 32768, 200, 0));
    send_request(make_request(fba_pkg::CMD_ALLOC, 0, 1, 0));          // next fit past the hint
    send_request(make_request(fba_pkg::CMD_RECOUNT, 65535, 1, 1));

    // Random phases over several frame_count settings, extremes included.
    // Small limit with a large used counter drives releases down to zero.
    foreach (frame_totals[p]) begin
      write_frame_total(frame_totals[p]);
      lim  = (frame_totals[p] < MAP_FRAMES) ? frame_totals[p] : MAP_FRAMES;
      span = (lim + 64 > 4096) ? 4096 : lim + 64;
      random_phase(span, 116);
    end

    drain_results();
    repeat (50) @(posedge clk);
    if (model.mismatches == 0 && model.owed.size() == 0) begin
      $display("[frame_bitmap_allocator] OK");
    end else begin
      $display("[frame_bitmap_allocator] ERROR");
    end
    $finish;
  end

endmodule
